// ===== rtl/variable_partition_allocator_defines.svh =====
// Assertion macros used by the allocator sequencer (vpa_ctrl).
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

// Implication in the same cycle.
`define VPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator assertion failed");

// Implication in the next cycle.
`define VPA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator assertion failed");

`endif

// ===== rtl/vpa_pkg.sv =====
// Shared constants and types of the variable partition allocator.
// No dependencies.
`timescale 1ns / 1ps
package vpa_pkg;
	localparam int MAX_SEGS_DEF  = 64;
	localparam int ADDR_BITS_DEF = 16;
	localparam int ID_BITS_DEF   = 16;

	localparam int FIELD_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_FIT  = 3'd1;
	localparam logic [2:0] ST_NO_ID   = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_ZERO_SZ = 3'd4;

	localparam logic CMD_ALLOC = 1'b0;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MEMORY_SIZE = 2'd1;

	typedef struct packed {
		logic [2:0]         status;
		logic [FIELD_W-1:0] alloc_id;
		logic [FIELD_W-1:0] start_addr;
	} vpa_res_t;
endpackage

// ===== rtl/vpa_seg_mem.sv =====
// Segment table storage: one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module vpa_seg_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6,
	parameter int WIDTH = 49
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [IDX_W-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/vpa_alu.sv =====
// Shared adder and subtractor used by the allocator sequencer.
// No dependencies.
`timescale 1ns / 1ps
module vpa_alu (
	input  logic        sub,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	always_comb begin
		if (sub) begin
			y = a - b;
		end else begin
			y = a + b;
		end
	end
endmodule

// ===== rtl/vpa_ctrl.sv =====
// Sequencer of the allocator: table scan, entry shifting and merging.
// Depends on vpa_pkg, the assertion macro header, and the segment memory and the shared adder in the top level.
`timescale 1ns / 1ps
`include "variable_partition_allocator_defines.svh"
module vpa_ctrl #(
	parameter int MAX_SEGS  = 64,
	parameter int ADDR_BITS = 16,
	parameter int ID_BITS   = 16,
	parameter int IDX_W     = 6,
	parameter int ENT_W     = 49
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [vpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vpa_pkg::FIELD_W-1:0]        cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [vpa_pkg::FIELD_W-1:0]        request_size,
	input  logic [vpa_pkg::FIELD_W-1:0]        block_id,
	output logic                               res_valid,
	input  logic                               res_ready,
	output vpa_pkg::vpa_res_t                  res,
	output logic                               mem_we,
	output logic [IDX_W-1:0]                   mem_waddr,
	output logic [ENT_W-1:0]                   mem_wdata,
	output logic [IDX_W-1:0]                   mem_raddr,
	input  logic [ENT_W-1:0]                   mem_rdata,
	output logic                               alu_sub,
	output logic [31:0]                        alu_a,
	output logic [31:0]                        alu_b,
	input  logic [31:0]                        alu_y
);
	import vpa_pkg::*;

	localparam int CNT_W  = $clog2(MAX_SEGS + 1);
	localparam int FREE_B = ID_BITS;
	localparam int SIZE_L = ID_BITS + 1;
	localparam int START_L = ID_BITS + 1 + ADDR_BITS;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_SCAN   = 13'b0000000000010,
		S_EVAL   = 13'b0000000000100,
		S_SUM    = 13'b0000000001000,
		S_SHIFT  = 13'b0000000010000,
		S_WR_HI  = 13'b0000000100000,
		S_WR_LO  = 13'b0000001000000,
		S_NRD    = 13'b0000010000000,
		S_NWT    = 13'b0000100000000,
		S_MRG1   = 13'b0001000000000,
		S_MRG2   = 13'b0010000000000,
		S_WRM    = 13'b0100000000000,
		S_RESULT = 13'b1000000000000
	} state_t;

	function automatic logic [ENT_W-1:0] pack_ent(input logic [ADDR_BITS-1:0] st,
		input logic [ADDR_BITS-1:0] sz, input logic fr, input logic [ID_BITS-1:0] ow);
		return {st, sz, fr, ow};
	endfunction

	function automatic logic [ADDR_BITS-1:0] ent_start(input logic [ENT_W-1:0] e);
		return e[ENT_W-1:START_L];
	endfunction

	function automatic logic [ADDR_BITS-1:0] ent_size(input logic [ENT_W-1:0] e);
		return e[START_L-1:SIZE_L];
	endfunction

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       new_count_q;
	logic [ID_BITS-1:0]     next_id_q;
	logic [1:0]             policy_q;
	logic [ADDR_BITS-1:0]   msize_q;
	logic                   init_q;
	logic                   cmd_q;
	logic [FIELD_W-1:0]     req_q;
	logic [FIELD_W-1:0]     bid_q;
	logic [CNT_W-1:0]       iss_q;
	logic                   pend_q;
	logic                   found_q;
	logic [CNT_W-1:0]       pick_q;
	logic [ENT_W-1:0]       pick_e_q;
	logic [ENT_W-1:0]       left_e_q;
	logic [ENT_W-1:0]       right_e_q;
	logic                   right_v_q;
	logic [ADDR_BITS-1:0]   rem_q;
	logic [ADDR_BITS-1:0]   hi_start_q;
	logic [ADDR_BITS-1:0]   cur_size_q;
	logic [CNT_W-1:0]       sh_rd_q;
	logic [CNT_W-1:0]       sh_last_q;
	logic [CNT_W-1:0]       sh_pidx_q;
	logic                   sh_more_q;
	logic                   sh_pend_q;
	logic                   sh_up_q;
	logic [1:0]             sh_d_q;
	vpa_res_t               res_q;

	logic                   rd_free;
	logic [31:0]            rd_size32;
	logic [31:0]            pick_size32;
	logic                   cand;
	logic                   take;
	logic                   stop;
	logic                   merge_r;
	logic                   merge_l;
	logic [ID_BITS-1:0]     id_inc;

	assign rd_free     = mem_rdata[FREE_B];
	assign rd_size32   = 32'(ent_size(mem_rdata));
	assign pick_size32 = 32'(ent_size(pick_e_q));
	assign merge_r     = right_v_q && right_e_q[FREE_B];
	assign merge_l     = (pick_q != '0) && left_e_q[FREE_B];
	assign id_inc      = next_id_q + ID_BITS'(1);

	always_comb begin
		cand = 1'b0;
		take = 1'b0;
		stop = 1'b0;
		if (cmd_q == CMD_ALLOC) begin
			cand = rd_free && !(rd_size32 < 32'(req_q));
			if (cand) begin
				if (!found_q) begin
					take = 1'b1;
					stop = (policy_q == FIT_FIRST);
				end else if (policy_q == FIT_BEST) begin
					take = rd_size32 < pick_size32;
				end else begin
					take = rd_size32 > pick_size32;
				end
			end
		end else begin
			cand = !rd_free && (32'(mem_rdata[ID_BITS-1:0]) == 32'(bid_q));
			take = cand;
			stop = cand;
		end
		if (!pend_q) begin
			take = 1'b0;
			stop = 1'b0;
		end
	end

	always_comb begin
		alu_sub = 1'b0;
		alu_a   = 32'(ent_size(pick_e_q));
		alu_b   = 32'(cur_size_q);
		unique case (state_q)
			S_EVAL: begin
				alu_sub = 1'b1;
				alu_b   = 32'(req_q);
			end
			S_SUM: begin
				alu_a = 32'(ent_start(pick_e_q));
				alu_b = 32'(req_q);
			end
			S_MRG1: begin
				alu_b = 32'(ent_size(right_e_q));
			end
			S_MRG2: begin
				alu_a = 32'(ent_size(left_e_q));
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = pack_ent('0, msize_q, 1'b1, '0);
		mem_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_we = init_q;
			end
			S_SCAN: begin
				mem_raddr = IDX_W'(iss_q);
			end
			S_SHIFT: begin
				mem_raddr = IDX_W'(sh_rd_q);
				mem_we    = sh_pend_q;
				mem_wdata = mem_rdata;
				if (sh_up_q) begin
					mem_waddr = IDX_W'(sh_pidx_q + CNT_W'(1));
				end else begin
					mem_waddr = IDX_W'(sh_pidx_q - CNT_W'(sh_d_q));
				end
			end
			S_WR_HI: begin
				mem_we    = 1'b1;
				mem_waddr = IDX_W'(pick_q + CNT_W'(1));
				mem_wdata = pack_ent(hi_start_q, rem_q, 1'b1, '0);
			end
			S_WR_LO: begin
				mem_we    = 1'b1;
				mem_waddr = IDX_W'(pick_q);
				mem_wdata = pack_ent(ent_start(pick_e_q), ADDR_BITS'(req_q), 1'b0, next_id_q);
			end
			S_EVAL: begin
				mem_we    = found_q && (alu_y == '0);
				mem_waddr = IDX_W'(pick_q);
				mem_wdata = pack_ent(ent_start(pick_e_q), ent_size(pick_e_q), 1'b0,
					next_id_q);
			end
			S_NRD: begin
				mem_raddr = IDX_W'(pick_q + CNT_W'(1));
			end
			S_WRM: begin
				mem_we = 1'b1;
				if (merge_l) begin
					mem_waddr = IDX_W'(pick_q - CNT_W'(1));
					mem_wdata = pack_ent(ent_start(left_e_q), cur_size_q, 1'b1, '0);
				end else begin
					mem_waddr = IDX_W'(pick_q);
					mem_wdata = pack_ent(ent_start(pick_e_q), cur_size_q, 1'b1, '0);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= CNT_W'(1);
			next_id_q <= ID_BITS'(1);
			policy_q  <= FIT_FIRST;
			msize_q   <= ADDR_BITS'(16'hFFFF);
			init_q    <= 1'b1;
			pend_q    <= 1'b0;
			sh_pend_q <= 1'b0;
			sh_more_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_FIT_POLICY) begin
					policy_q <= cfg_wr_data[1:0];
				end else if (cfg_index == REG_MEMORY_SIZE) begin
					msize_q <= ADDR_BITS'(cfg_wr_data);
					init_q  <= 1'b1;
					count_q <= (ADDR_BITS'(cfg_wr_data) != '0) ? CNT_W'(1) : '0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (init_q && !cfg_wr_en) begin
						init_q <= 1'b0;
					end
					if (in_valid && in_ready) begin
						cmd_q   <= command;
						req_q   <= request_size;
						bid_q   <= block_id;
						iss_q   <= '0;
						pend_q  <= 1'b0;
						found_q <= 1'b0;
						pick_q  <= '0;
						res_q   <= '{
							status: (command == CMD_ALLOC && request_size == '0) ?
								ST_ZERO_SZ : ST_OK,
							alloc_id: '0,
							start_addr: '0
						};
						if (command == CMD_ALLOC && request_size == '0) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (pend_q && !take) begin
						left_e_q <= mem_rdata;
					end
					if (take) begin
						found_q  <= 1'b1;
						pick_q   <= iss_q - CNT_W'(1);
						pick_e_q <= mem_rdata;
					end
					if (stop || (!pend_q && iss_q >= count_q)) begin
						pend_q <= 1'b0;
						if (cmd_q == CMD_ALLOC) begin
							state_q <= S_EVAL;
						end else if (stop) begin
							state_q <= S_NRD;
						end else begin
							res_q.status <= ST_NO_ID;
							state_q      <= S_RESULT;
						end
					end else if (iss_q < count_q) begin
						pend_q <= 1'b1;
						iss_q  <= iss_q + CNT_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
				end
				S_EVAL: begin
					rem_q <= ADDR_BITS'(alu_y);
					if (!found_q) begin
						res_q.status <= ST_NO_FIT;
						state_q      <= S_RESULT;
					end else if (alu_y == '0) begin
						next_id_q        <= (id_inc == '0) ? ID_BITS'(1) : id_inc;
						res_q.alloc_id   <= FIELD_W'(next_id_q);
						res_q.start_addr <= FIELD_W'(ent_start(pick_e_q));
						state_q          <= S_RESULT;
					end else if (count_q == CNT_W'(MAX_SEGS)) begin
						res_q.status <= ST_FULL;
						state_q      <= S_RESULT;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					hi_start_q  <= ADDR_BITS'(alu_y);
					new_count_q <= count_q + CNT_W'(1);
					sh_up_q     <= 1'b1;
					sh_d_q      <= 2'd1;
					sh_rd_q     <= count_q - CNT_W'(1);
					sh_last_q   <= pick_q + CNT_W'(1);
					sh_more_q   <= (32'(pick_q) + 32'd2) <= 32'(count_q);
					sh_pend_q   <= 1'b0;
					state_q     <= S_SHIFT;
				end
				S_SHIFT: begin
					sh_pidx_q <= sh_rd_q;
					sh_pend_q <= sh_more_q;
					if (sh_more_q) begin
						if (sh_rd_q == sh_last_q) begin
							sh_more_q <= 1'b0;
						end else if (sh_up_q) begin
							sh_rd_q <= sh_rd_q - CNT_W'(1);
						end else begin
							sh_rd_q <= sh_rd_q + CNT_W'(1);
						end
					end else if (!sh_pend_q) begin
						count_q <= new_count_q;
						state_q <= (cmd_q == CMD_ALLOC) ? S_WR_HI : S_RESULT;
					end
				end
				S_WR_HI: begin
					state_q <= S_WR_LO;
				end
				S_WR_LO: begin
					next_id_q        <= (id_inc == '0) ? ID_BITS'(1) : id_inc;
					res_q.alloc_id   <= FIELD_W'(next_id_q);
					res_q.start_addr <= FIELD_W'(ent_start(pick_e_q));
					state_q          <= S_RESULT;
				end
				S_NRD: begin
					right_v_q <= (32'(pick_q) + 32'd1) < 32'(count_q);
					if ((32'(pick_q) + 32'd1) < 32'(count_q)) begin
						state_q <= S_NWT;
					end else begin
						state_q <= S_MRG1;
					end
				end
				S_NWT: begin
					right_e_q <= mem_rdata;
					state_q   <= S_MRG1;
				end
				S_MRG1: begin
					cur_size_q <= merge_r ? ADDR_BITS'(alu_y) : ent_size(pick_e_q);
					state_q    <= S_MRG2;
				end
				S_MRG2: begin
					if (merge_l) begin
						cur_size_q <= ADDR_BITS'(alu_y);
					end
					state_q <= S_WRM;
				end
				S_WRM: begin
					sh_up_q     <= 1'b0;
					sh_d_q      <= {1'b0, merge_r} + {1'b0, merge_l};
					sh_rd_q     <= pick_q + CNT_W'(1) + CNT_W'(merge_r);
					sh_last_q   <= count_q - CNT_W'(1);
					sh_more_q   <= (merge_r || merge_l) &&
						((32'(pick_q) + 32'd2 + 32'(merge_r)) <= 32'(count_q));
					sh_pend_q   <= 1'b0;
					new_count_q <= count_q - CNT_W'(merge_r) - CNT_W'(merge_l);
					state_q     <= S_SHIFT;
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !init_q;
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	`VPA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_SEGS))
	`VPA_ASSERT_IMP(a_id_nonzero, 1'b1, next_id_q != '0)
	`VPA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`VPA_ASSERT_IMP(a_shift_in_table, sh_pend_q && state_q == S_SHIFT, sh_pidx_q < count_q)
endmodule

// ===== rtl/variable_partition_allocator.sv =====
// Variable partition allocator: a request scans the table at one entry per cycle; an
// allocation that splits an entry then shifts later entries up at one per cycle and
// writes both parts, while a free merges with free neighbours, then shifts entries down.
// One item is in work at a time.
// A finished result waits in an output register; the next item is taken once it moves there.
// After reset or a memory_size write, entry 0 is written while idle, before ready rises.
`timescale 1ns / 1ps
module variable_partition_allocator #(
	parameter int MAX_SEGS  = vpa_pkg::MAX_SEGS_DEF,
	parameter int ADDR_BITS = vpa_pkg::ADDR_BITS_DEF,
	parameter int ID_BITS   = vpa_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [vpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vpa_pkg::FIELD_W-1:0]   cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [vpa_pkg::FIELD_W-1:0]   request_size,
	input  logic [vpa_pkg::FIELD_W-1:0]   block_id,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [vpa_pkg::FIELD_W-1:0]   allocated_id,
	output logic [vpa_pkg::FIELD_W-1:0]   start_address
);
	import vpa_pkg::*;

	localparam int IDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
	localparam int ENT_W = 2 * ADDR_BITS + 1 + ID_BITS;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_rdata;
	logic             alu_sub;
	logic [31:0]      alu_a;
	logic [31:0]      alu_b;
	logic [31:0]      alu_y;
	logic             res_valid;
	logic             res_ready;
	vpa_res_t         res;
	logic             out_valid_q;
	vpa_res_t         out_q;

	vpa_seg_mem #(.DEPTH(MAX_SEGS), .IDX_W(IDX_W), .WIDTH(ENT_W)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

	vpa_alu u_alu (.sub(alu_sub), .a(alu_a), .b(alu_b), .y(alu_y));

	vpa_ctrl #(
		.MAX_SEGS(MAX_SEGS), .ADDR_BITS(ADDR_BITS), .ID_BITS(ID_BITS),
		.IDX_W(IDX_W), .ENT_W(ENT_W)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.request_size(request_size), .block_id(block_id),
		.res_valid(res_valid), .res_ready(res_ready), .res(res),
		.mem_we(mem_we), .mem_waddr(mem_waddr), .mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr), .mem_rdata(mem_rdata),
		.alu_sub(alu_sub), .alu_a(alu_a), .alu_b(alu_b), .alu_y(alu_y)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign allocated_id  = out_q.alloc_id;
	assign start_address = out_q.start_addr;
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for variable_partition_allocator: an in-bench segment table
// predicts every status, id and start address under changing fit policies and memory sizes.
// Depends on vpa_pkg and the allocator RTL only.
`timescale 1ns / 1ps
module tb_top;
	import vpa_pkg::*;

	localparam logic       CMD_FREE   = 1'b1;
	localparam logic [1:0] FIT_WORST  = 2'd2;
	localparam logic [1:0] FIT_UNUSED = 2'd3;
	localparam int         NSEG       = MAX_SEGS_DEF;
	localparam int         DRAIN_CYC  = 2 * NSEG + 20;
	localparam longint     CYCLE_CAP  = 3000000;

	class alloc_scoreboard;
		logic [15:0] seg_base[NSEG];
		logic [15:0] seg_len[NSEG];
		bit          seg_open[NSEG];
		logic [15:0] seg_tag[NSEG];
		int          used;
		logic [15:0] next_tag;
		logic [1:0]  policy;
		vpa_res_t    want_q[$];
		int          mismatches;
		int          checked;

		function void load_table(logic [15:0] total);
			for (int k = 0; k < NSEG; k++) begin
				seg_base[k] = '0;
				seg_len[k] = '0;
				seg_open[k] = 0;
				seg_tag[k] = '0;
			end
			used = 0;
			if (total != 0) begin
				seg_len[0] = total;
				seg_open[0] = 1;
				used = 1;
			end
		endfunction

		function void power_on();
			policy = FIT_FIRST;
			next_tag = 16'd1;
			load_table(16'hFFFF);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			if (idx == REG_FIT_POLICY)
				policy = data[1:0];
			else if (idx == REG_MEMORY_SIZE)
				load_table(data);
		endfunction

		function void remove_at(int pos);
			for (int k = pos; k + 1 < used; k++) begin
				seg_base[k] = seg_base[k + 1];
				seg_len[k] = seg_len[k + 1];
				seg_open[k] = seg_open[k + 1];
				seg_tag[k] = seg_tag[k + 1];
			end
			used--;
			seg_base[used] = '0;
			seg_len[used] = '0;
			seg_open[used] = 0;
			seg_tag[used] = '0;
		endfunction

		function logic [15:0] live_tag();
			int idx[$];
			for (int k = 0; k < used; k++)
				if (!seg_open[k])
					idx.push_back(k);
			if (idx.size() == 0)
				return 16'($urandom_range(0, 40));
			return seg_tag[idx[$urandom_range(0, idx.size() - 1)]];
		endfunction

		function void note_request(logic cmd, logic [15:0] size, logic [15:0] tag);
			vpa_res_t r;
			int pick;
			int k;
			bit found;
			logic [15:0] rest;
			r = '0;
			found = 0;
			pick = 0;
			if (cmd == CMD_ALLOC) begin
				if (size == 0) begin
					r.status = ST_ZERO_SZ;
				end else begin
					for (k = 0; k < used; k++) begin
						if (!seg_open[k] || seg_len[k] < size)
							continue;
						if (!found) begin
							pick = k;
							found = 1;
							if (policy == FIT_FIRST)
								break;
						end else if (policy == FIT_BEST) begin
							if (seg_len[k] < seg_len[pick])
								pick = k;
						end else if (seg_len[k] > seg_len[pick]) begin
							pick = k;
						end
					end
					if (!found) begin
						r.status = ST_NO_FIT;
					end else begin
						rest = seg_len[pick] - size;
						if (rest != 0 && used >= NSEG) begin
							r.status = ST_FULL;
						end else begin
							r.alloc_id = next_tag;
							r.start_addr = seg_base[pick];
							if (rest != 0) begin
								for (k = used; k > pick; k--) begin
									seg_base[k] = seg_base[k - 1];
									seg_len[k] = seg_len[k - 1];
									seg_open[k] = seg_open[k - 1];
									seg_tag[k] = seg_tag[k - 1];
								end
								used++;
								seg_base[pick + 1] = seg_base[pick] + size;
								seg_len[pick + 1] = rest;
								seg_len[pick] = size;
							end
							seg_open[pick] = 0;
							seg_tag[pick] = next_tag;
							next_tag++;
							if (next_tag == 0)
								next_tag = 16'd1;
						end
					end
				end
			end else begin
				for (k = 0; k < used; k++)
					if (!seg_open[k] && seg_tag[k] == tag)
						break;
				if (k >= used) begin
					r.status = ST_NO_ID;
				end else begin
					seg_open[k] = 1;
					seg_tag[k] = '0;
					if (k + 1 < used && seg_open[k + 1]) begin
						seg_len[k] = seg_len[k] + seg_len[k + 1];
						remove_at(k + 1);
					end
					if (k > 0 && seg_open[k - 1]) begin
						seg_len[k - 1] = seg_len[k - 1] + seg_len[k];
						remove_at(k);
					end
				end
			end
			want_q.push_back(r);
		endfunction

		function void check_result(logic [2:0] st, logic [15:0] aid, logic [15:0] sa);
			vpa_res_t w;
			checked++;
			if (want_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: status %0d id %0d start %0d", st, aid, sa);
				return;
			end
			w = want_q.pop_front();
			if (st !== w.status || aid !== w.alloc_id || sa !== w.start_addr) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch: expected status %0d id %0d start %0d, got %0d %0d %0d",
						w.status, w.alloc_id, w.start_addr, st, aid, sa);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [FIELD_W-1:0]   cfg_wr_data;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic [FIELD_W-1:0]   request_size;
	logic [FIELD_W-1:0]   block_id;
	logic                 out_valid;
	logic                 out_ready;
	logic [2:0]           status;
	logic [FIELD_W-1:0]   allocated_id;
	logic [FIELD_W-1:0]   start_address;

	alloc_scoreboard sb;
	bit              steady_send;
	bit              steady_recv;
	longint          cycles = 0;
	int              sent;
	logic [15:0]     cur_mem;

	variable_partition_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .request_size(request_size), .block_id(block_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .allocated_id(allocated_id), .start_address(start_address)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, allocated_id, start_address);

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady_recv ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_item(logic cmd, logic [15:0] size, logic [15:0] tag);
		int gap;
		gap = steady_send ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		request_size <= size;
		block_id <= tag;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(cmd, size, tag);
		sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.want_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, data);
		if (idx == REG_MEMORY_SIZE)
			cur_mem = data;
	endtask

	task automatic random_item(bit fill);
		int r;
		logic [15:0] size;
		r = $urandom_range(0, 99);
		if (fill || r < 55) begin
			r = $urandom_range(0, 99);
			if (fill)
				size = 16'($urandom_range(1, 4));
			else if (r < 3)
				size = '0;
			else if (r < 10)
				size = 16'($urandom);
			else if (r < 25)
				size = 16'($urandom_range(1, cur_mem == 0 ? 1 : cur_mem));
			else
				size = 16'($urandom_range(1, cur_mem / 8 + 1));
			send_item(CMD_ALLOC, size, 16'($urandom));
		end else begin
			r = $urandom_range(0, 99);
			send_item(CMD_FREE, 16'($urandom),
				r < 80 ? sb.live_tag() : r < 90 ? 16'($urandom) : 16'($urandom_range(0, 60)));
		end
	endtask

	initial begin
		logic [15:0] mems[12];
		sb = new();
		sb.power_on();
		mems = '{16'd300, 16'd1, 16'd0, 16'hFFFF, 16'd4096, 16'd64,
			16'd1000, 16'hFFFF, 16'd20, 16'd50000, 16'd2, 16'd700};
		cur_mem = 16'hFFFF;
		cycles = 0;
		sent = 0;
		steady_send = 0;
		steady_recv = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		command = CMD_ALLOC;
		request_size = '0;
		block_id = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(CMD_ALLOC, 16'd0, 16'd0);
		send_item(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
		send_item(CMD_ALLOC, 16'd1, 16'd0);
		send_item(CMD_FREE, 16'hFFFF, 16'd1);
		send_item(CMD_FREE, 16'd0, 16'd0);
		send_item(CMD_FREE, 16'd0, 16'hFFFF);
		send_item(CMD_ALLOC, 16'd100, 16'd0);
		send_item(CMD_ALLOC, 16'd200, 16'd0);
		send_item(CMD_ALLOC, 16'd300, 16'd0);
		send_item(CMD_FREE, 16'd0, 16'd3);
		send_item(CMD_FREE, 16'd0, 16'd2);
		send_item(CMD_FREE, 16'd0, 16'd4);
		send_item(CMD_ALLOC, 16'd100, 16'd0);
		send_item(CMD_ALLOC, 16'd50, 16'd0);
		send_item(CMD_FREE, 16'd0, 16'd5);
		send_item(CMD_ALLOC, 16'd40, 16'd0);
		send_item(CMD_ALLOC, 16'd60, 16'd0);
		wait_idle();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(REG_FIT_POLICY, 16'(ph % 4 == 3 ? FIT_UNUSED : ph % 4));
			write_reg(REG_MEMORY_SIZE, mems[ph]);
			steady_send = (ph % 5 == 2);
			steady_recv = (ph % 4 == 1);
			for (int n = 0; n < 160; n++) begin
				random_item(ph == 3 && n < 80);
				if (n == 100 && ph == 6)
					wait_idle();
			end
			wait_idle();
		end
		write_reg(REG_FIT_POLICY, 16'(FIT_WORST));

		in_valid <= 1'b0;
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		$display("Sent %0d requests over 12 policy and memory size settings; %0d results checked.",
			sent, sb.checked);
		if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
